>>> design/rasa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasa_pkg
// Shared types and constants for the rotated sorted array search block.
// ----------------------------------------------------------------------------
package rasa_pkg;

    localparam int STORE_DEPTH = 1024;
    localparam int IDX_W       = $clog2(STORE_DEPTH);
    localparam int ELEM_W      = 32;

    localparam logic REQ_WRITE  = 1'b0;
    localparam logic REQ_SEARCH = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CMP,
        ST_READ_HI,
        ST_CMP_HI
    } t_state;

    // one write port and two read ports into the element store
    typedef struct packed {
        logic              wr_en;
        logic [IDX_W-1:0]  wr_addr;
        logic [IDX_W-1:0]  rd_addr_a;
        logic [IDX_W-1:0]  rd_addr_b;
    } t_store_req;

endpackage

>>> design/rasa_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rasa_store
// Element store: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module rasa_store
    import rasa_pkg::*;
(
    input  logic                     i_clk,
    input  t_store_req               i_req,
    input  logic signed [ELEM_W-1:0] i_wr_data,
    output logic signed [ELEM_W-1:0] o_rd_data_a,
    output logic signed [ELEM_W-1:0] o_rd_data_b
);

    logic signed [ELEM_W-1:0] r_mem [STORE_DEPTH];
    logic signed [ELEM_W-1:0] r_rd_a;
    logic signed [ELEM_W-1:0] r_rd_b;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_wr_data;
        end
        r_rd_a <= r_mem[i_req.rd_addr_a];
        r_rd_b <= r_mem[i_req.rd_addr_b];
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

>>> design/rotated_array_binary_search.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rotated_array_binary_search
// Binary search of a rotated sorted array held in an on-chip store.
// ----------------------------------------------------------------------------
// A write item is written into the store when accepted and gives no result. A
// search item runs halving steps: read the middle and low elements, then decide;
// when the left half is out of order the high element must also be read and
// compared, as the element store has only two read ports. busy stays high until
// the result is shown; the result is on o_found / o_found_index for exactly one
// cycle with o_done high and cannot be held off by the receiver. Searching
// entries never written gives an undefined answer.
// ----------------------------------------------------------------------------
module rotated_array_binary_search
    import rasa_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     start,
    output logic                     busy,
    input  logic                     i_req_type,
    input  logic [IDX_W-1:0]         i_write_index,
    input  logic signed [ELEM_W-1:0] i_element_value,
    input  logic signed [ELEM_W-1:0] i_search_key,
    input  logic [IDX_W-1:0]         i_range_low,
    input  logic [IDX_W-1:0]         i_range_high,
    output logic                     o_done,
    output logic                     o_found,
    output logic [IDX_W-1:0]         o_found_index
);

    t_state                   r_state, n_state;
    logic [IDX_W-1:0]         r_lo, n_lo;
    logic [IDX_W-1:0]         r_hi, n_hi;
    logic [IDX_W-1:0]         r_mid;
    logic signed [ELEM_W-1:0] r_key;
    logic signed [ELEM_W-1:0] r_vm;
    logic                     r_done, n_done;
    logic                     r_found, n_found;
    logic [IDX_W-1:0]         r_found_index, n_found_index;

    t_store_req               store_req;
    logic signed [ELEM_W-1:0] rd_a, rd_b;
    logic [IDX_W:0]           mid_sum;
    logic [IDX_W-1:0]         mid;
    logic                     accept;
    logic                     go_left, hit, left_sorted, empty_rng;

    rasa_store u_store (
        .i_clk       (i_clk),
        .i_req       (store_req),
        .i_wr_data   (i_element_value),
        .o_rd_data_a (rd_a),
        .o_rd_data_b (rd_b)
    );

    assign accept    = start && (r_state == ST_IDLE);
    assign mid_sum   = {1'b0, r_lo} + {1'b0, r_hi};
    assign mid       = mid_sum[IDX_W:1];
    assign empty_rng = i_range_low > i_range_high;

    // rd_a carries the middle element in ST_CMP, the high element in ST_CMP_HI
    assign hit         = (rd_a == r_key);
    assign left_sorted = (rd_b <= rd_a);

    always_comb begin
        go_left = 1'b0;
        case (r_state)
            ST_CMP:    go_left = (rd_b <= r_key) && (r_key < rd_a);
            ST_CMP_HI: go_left = !((r_vm < r_key) && (r_key <= rd_a));
            default:   go_left = 1'b0;
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (accept && (i_req_type == REQ_SEARCH) && !empty_rng) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: n_state = ST_CMP;
            ST_CMP: begin
                if (hit) begin
                    n_state = ST_IDLE;
                end else if (!left_sorted) begin
                    n_state = ST_READ_HI;
                end else if (go_left ? (r_mid == r_lo) : (r_mid == r_hi)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            ST_READ_HI: n_state = ST_CMP_HI;
            ST_CMP_HI: begin
                if (go_left ? (r_mid == r_lo) : (r_mid == r_hi)) begin
                    n_state = ST_IDLE;
                end else begin
                    n_state = ST_READ;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        busy                = (r_state != ST_IDLE);
        store_req.wr_en     = accept && (i_req_type == REQ_WRITE);
        store_req.wr_addr   = i_write_index;
        store_req.rd_addr_a = (r_state == ST_READ_HI) ? r_hi : mid;
        store_req.rd_addr_b = r_lo;
        n_lo                = r_lo;
        n_hi                = r_hi;
        n_done              = 1'b0;
        n_found             = 1'b0;
        n_found_index       = '0;
        case (r_state)
            ST_IDLE: begin
                n_lo = i_range_low;
                n_hi = i_range_high;
                // an empty range answers at once
                if (accept && (i_req_type == REQ_SEARCH) && empty_rng) begin
                    n_done = 1'b1;
                end
            end
            ST_CMP: begin
                if (hit) begin
                    n_done        = 1'b1;
                    n_found       = 1'b1;
                    n_found_index = r_mid;
                end else if (left_sorted) begin
                    if (go_left) begin
                        n_hi   = r_mid - IDX_W'(1);
                        n_done = (r_mid == r_lo);
                    end else begin
                        n_lo   = r_mid + IDX_W'(1);
                        n_done = (r_mid == r_hi);
                    end
                end
            end
            ST_CMP_HI: begin
                if (go_left) begin
                    n_hi   = r_mid - IDX_W'(1);
                    n_done = (r_mid == r_lo);
                end else begin
                    n_lo   = r_mid + IDX_W'(1);
                    n_done = (r_mid == r_hi);
                end
            end
            default: begin
                n_lo = r_lo;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_lo          <= n_lo;
        r_hi          <= n_hi;
        r_found       <= n_found;
        r_found_index <= n_found_index;
        if (accept) begin
            r_key <= i_search_key;
        end
        if (r_state == ST_READ) begin
            r_mid <= mid;
        end
        // hold the middle element for the out-of-order half test
        if (r_state == ST_CMP) begin
            r_vm <= rd_a;
        end
    end

    assign o_done        = r_done;
    assign o_found       = r_found;
    assign o_found_index = r_found_index;

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !busy)
        else $error("result shown while a search is still running");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_found) |-> (o_found_index == '0))
        else $error("miss reported with non-zero index");

    a_mid_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CMP) |-> ((r_lo <= r_mid) && (r_mid <= r_hi)))
        else $error("probe index outside search window");

    a_no_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        store_req.wr_en |-> (r_state == ST_IDLE))
        else $error("store written during a search");

endmodule
